FILE: hw/rtl/stream_duplicate_filter_macros.svh
// Assertion macros for the stream duplicate filter.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef STREAM_DUPLICATE_FILTER_MACROS_SVH
`define STREAM_DUPLICATE_FILTER_MACROS_SVH

// Property checked at every rising edge outside reset.
`define SDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define SDF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/sdf_pkg.sv
// Shared types and constants for the stream duplicate filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package sdf_pkg;

  // Default number of distinct values held per set.
  localparam int unsigned SDF_TABLE_DEPTH = 64;
  localparam int unsigned SDF_VALUE_W     = 32;

  // One input transaction as it travels through the queue.
  typedef struct packed {
    logic signed [SDF_VALUE_W-1:0] value;
    logic                          last;
  } sdf_item_t;

  // Table status reported by the search engine.
  typedef struct packed {
    logic busy;
    logic empty;
    logic full;
  } sdf_stat_t;

  // Search engine sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } sdf_state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/stream_duplicate_filter.sv
// Top level of the stream duplicate filter: input queue feeding the table search engine.
// Depends on sdf_pkg, sdf_queue, sdf_engine and stream_duplicate_filter_macros.svh.
//
//   Channel | Direction | Handshake              | Payload
//   input   | in        | in_valid_i, in_stall_o | value_i, last_i
//   output  | out       | out_valid_o, out_stall_i | value_out_o, keep_o, overflow_o, last_out_o
//
// A transaction passes through the queue, then the engine scans the table entry by entry
// until a match or the last held value, so a new value is checked against all n entries.
// The scan is set by the single read port of the table memory, one entry per cycle.
// Reset clears the fill count, so the table starts empty without a clearing pass.
// A stalled output holds the result register; the queue still takes up to two
// transactions, and in_stall_o rises only when both entries are occupied.
`default_nettype none

`include "stream_duplicate_filter_macros.svh"

module stream_duplicate_filter
  import sdf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = SDF_TABLE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SDF_VALUE_W-1:0] value_i,
  input  wire logic                          last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SDF_VALUE_W-1:0]      value_out_o,
  output logic                               keep_o,
  output logic                               overflow_o,
  output logic                               last_out_o
);

  sdf_item_t in_item, q_item;
  sdf_stat_t stat;
  logic      q_valid, q_pop;

  assign in_item.value = value_i;
  assign in_item.last  = last_i;

  // Front: queue of accepted transactions.
  sdf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (in_item),
    .full_o  (in_stall_o),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  // Back: table search and result register.
  sdf_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_out_o (value_out_o),
    .keep_o      (keep_o),
    .overflow_o  (overflow_o),
    .last_out_o  (last_out_o)
  );

  // Consistency checks between the result register and the table state.
  // The reset check is a non-overlapping implication; the registers reset
  // asynchronously when rst_ni falls.
  `SDF_ASSERT(a_pop_needs_item, q_pop |-> q_valid, "engine popped an empty queue")
  `SDF_ASSERT(a_ovf_is_kept, out_valid_o && overflow_o |-> keep_o, "overflow on a dropped value")
  `SDF_ASSERT(a_ovf_table_full, out_valid_o && overflow_o && !last_out_o |-> stat.full, "overflow with room left in the table")
  `SDF_ASSERT(a_last_clears, out_valid_o && last_out_o |-> stat.empty, "table not cleared after set end")
  `SDF_ASSERT_ALWAYS(a_reset_state, !rst_ni |=> stat.empty && !stat.busy, "engine not idle in reset")

endmodule

`default_nettype wire

FILE: hw/rtl/sdf_queue.sv
// Two-entry queue that accepts input transactions and decouples them from the engine.
// Depends on sdf_pkg for the item type.
`default_nettype none

module sdf_queue
  import sdf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire sdf_item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  input  wire logic      pop_i,
  output sdf_item_t      item_o
);

  sdf_item_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  // Handshake qualifiers; the engine pops only when an entry is present.
  assign full_o  = fill_q[1];
  assign valid_o = (fill_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sdf_engine.sv
// Search engine: scans the table of seen values, updates it and drives the result register.
// Depends on sdf_pkg for the item, status and state types.
`default_nettype none

module sdf_engine
  import sdf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = SDF_TABLE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire sdf_item_t                     q_item_i,
  output logic                               q_pop_o,
  output sdf_stat_t                          stat_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SDF_VALUE_W-1:0]      value_out_o,
  output logic                               keep_o,
  output logic                               overflow_o,
  output logic                               last_out_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  sdf_state_e                    state_q, state_d;
  sdf_item_t                     cur_q;
  logic [AW-1:0]                 idx_q, idx_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic                          hit_q, hit_d;
  logic [SDF_VALUE_W-1:0]        mem [TABLE_DEPTH];
  logic [SDF_VALUE_W-1:0]        rd_data_q;
  logic [AW-1:0]                 rd_addr;
  logic                          match, scan_end, full, out_free, done_fire, store;
  logic                          out_valid_q;
  logic signed [SDF_VALUE_W-1:0] out_value_q;
  logic                          out_keep_q, out_ovf_q, out_last_q;

  // Scan qualifiers. rd_data_q holds the entry at idx_q while scanning.
  assign match     = (rd_data_q == SDF_VALUE_W'(cur_q.value));
  assign scan_end  = ((CW'(idx_q) + CW'(1)) == cnt_q);
  assign full      = (cnt_q == DepthC);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign done_fire = (state_q == S_DONE) && out_free;
  assign store     = done_fire && !hit_q && !full;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          state_d = (cnt_q == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match || scan_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: queue pop, read address, scan index and hit flag.
  always_comb begin
    q_pop_o = 1'b0;
    rd_addr = '0;
    idx_d   = idx_q;
    hit_d   = hit_q;
    unique case (state_q)
      S_IDLE: begin
        q_pop_o = q_valid_i;
        idx_d   = '0;
        hit_d   = 1'b0;
      end
      S_SCAN: begin
        rd_addr = idx_q + AW'(1);
        hit_d   = hit_q | match;
        if (!(match || scan_end)) begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Table fill count; a set end empties the table.
  always_comb begin
    cnt_d = cnt_q;
    if (done_fire) begin
      if (cur_q.last) begin
        cnt_d = '0;
      end else if (store) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      hit_q   <= hit_d;
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Current transaction and result payload.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_item_i;
    end
    if (done_fire) begin
      out_value_q <= cur_q.value;
      out_keep_q  <= !hit_q;
      out_ovf_q   <= !hit_q && full;
      out_last_q  <= cur_q.last;
    end
  end

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (store) begin
      mem[cnt_q[AW-1:0]] <= SDF_VALUE_W'(cur_q.value);
    end
    rd_data_q <= mem[rd_addr];
  end

  assign stat_o.busy  = (state_q != S_IDLE);
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = full;

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_value_q;
  assign keep_o      = out_keep_q;
  assign overflow_o  = out_ovf_q;
  assign last_out_o  = out_last_q;

endmodule

`default_nettype wire
